// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define KIRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define KIRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/kirs_pkg.sv -----
// Types, codes and pass table of the keyed image row scrambler.
package kirs_pkg;

    // request modes
    localparam logic [1:0] MODE_KEY  = 2'd0;
    localparam logic [1:0] MODE_PIX  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;
    localparam logic [1:0] CFG_FWD  = 2'd2;
    localparam int CFG_DW = 9;

    localparam logic [3:0] LAST_PASS = 4'd10;

    typedef struct packed {
        logic [1:0]  mode;
        logic [13:0] key_index;
        logic [13:0] key_value;
        logic [23:0] pixel_in;
    } t_req;

    typedef struct packed {
        logic [23:0] pixel_out;
        logic        last_pixel;
    } t_res;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD_KEY, OP_LOAD_PIX, OP_READ, OP_START, OP_PASS_INIT,
        OP_CLEAR, OP_COPY, OP_KEY_RD, OP_KEY_TEST, OP_ROW_SET, OP_ROW_MOVE,
        OP_SL_ROW, OP_SL_MOVE, OP_SL_NORM, OP_ROT
    } t_op;

    typedef enum logic [1:0] {PK_SCR, PK_SLANT, PK_ROT_CW, PK_ROT_CCW} t_pass_kind;

    typedef struct packed {
        t_op        op;
        logic [3:0] pass_idx;
    } t_cmd;

    typedef struct packed {
        logic full_next;
        logic read_last;
        logic cnt_last;
        logic key_last;
        logic key_hit;
        logic placed_full;
        logic row_last;
        logic norm_done;
        logic rows_done;
        logic rot_last;
        logic out_busy;
    } t_stat;

    // pass order: scramble, slant, scramble, rotate cw, ... , scramble
    function automatic t_pass_kind pass_kind(input logic [3:0] p);
        t_pass_kind k;
        case (p)
            4'd1, 4'd5, 4'd9: k = PK_SLANT;
            4'd3:             k = PK_ROT_CW;
            4'd7:             k = PK_ROT_CCW;
            default:          k = PK_SCR;
        endcase
        return k;
    endfunction

    // passes 4..7 work on the transposed (cols x rows) frame
    function automatic logic pass_swap(input logic [3:0] p);
        return (p >= 4'd4) && (p <= 4'd7);
    endfunction

endpackage

// ----- rtl/kirs_ctrl.sv -----
// Sequencer: request decode and pass/phase state machine.
module kirs_ctrl import kirs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  logic [1:0] i_mode,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_PASS, S_CLEAR, S_KEY_RD, S_KEY_TEST, S_ROW_SET,
        S_ROW_MOVE, S_SL_ROW, S_SL_MOVE, S_SL_NORM, S_ROT, S_DRAIN, S_COPY,
        S_DRAIN2
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_pass, n_pass;
    logic       r_result_ready, n_result_ready;
    logic       w_fire;

    assign o_req_ready = (r_state == S_IDLE) && !i_stat.out_busy;
    assign w_fire      = i_req_valid && o_req_ready;

    // next state and command
    always_comb begin
        n_state        = r_state;
        n_pass         = r_pass;
        n_result_ready = r_result_ready;
        o_cmd.op       = OP_NONE;
        o_cmd.pass_idx = r_pass;
        case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    if (i_mode == MODE_KEY) begin
                        o_cmd.op = OP_LOAD_KEY;
                    end else if (i_mode == MODE_PIX && !r_result_ready) begin
                        o_cmd.op = OP_LOAD_PIX;
                        if (i_stat.full_next) n_state = S_START;
                    end else if (i_mode == MODE_READ && r_result_ready) begin
                        o_cmd.op = OP_READ;
                        if (i_stat.read_last) n_result_ready = 1'b0;
                    end
                end
            end
            S_START: begin
                o_cmd.op = OP_START;
                n_pass   = 4'd0;
                n_state  = S_PASS;
            end
            S_PASS: begin
                o_cmd.op = OP_PASS_INIT;
                case (pass_kind(r_pass))
                    PK_SCR:   n_state = S_CLEAR;
                    PK_SLANT: n_state = S_SL_ROW;
                    default:  n_state = S_ROT;
                endcase
            end
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.cnt_last) n_state = S_KEY_RD;
            end
            S_KEY_RD: begin
                if (i_stat.placed_full) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.op = OP_KEY_RD;
                    n_state  = S_KEY_TEST;
                end
            end
            S_KEY_TEST: begin
                o_cmd.op = OP_KEY_TEST;
                if (i_stat.key_hit)       n_state = S_ROW_SET;
                else if (i_stat.key_last) n_state = S_DRAIN;
                else                      n_state = S_KEY_RD;
            end
            S_ROW_SET: begin
                o_cmd.op = OP_ROW_SET;
                n_state  = S_ROW_MOVE;
            end
            S_ROW_MOVE: begin
                o_cmd.op = OP_ROW_MOVE;
                if (i_stat.row_last) n_state = i_stat.key_last ? S_DRAIN : S_KEY_RD;
            end
            S_SL_ROW: begin
                o_cmd.op = OP_SL_ROW;
                n_state  = S_SL_MOVE;
            end
            S_SL_MOVE: begin
                o_cmd.op = OP_SL_MOVE;
                if (i_stat.row_last) n_state = S_SL_NORM;
            end
            S_SL_NORM: begin
                o_cmd.op = OP_SL_NORM;
                if (i_stat.norm_done) n_state = i_stat.rows_done ? S_DRAIN : S_SL_ROW;
            end
            S_ROT: begin
                o_cmd.op = OP_ROT;
                if (i_stat.rot_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_COPY;
            end
            S_COPY: begin
                o_cmd.op = OP_COPY;
                if (i_stat.cnt_last) n_state = S_DRAIN2;
            end
            S_DRAIN2: begin
                if (r_pass == LAST_PASS) begin
                    n_state        = S_IDLE;
                    n_result_ready = 1'b1;
                end else begin
                    n_pass  = r_pass + 4'd1;
                    n_state = S_PASS;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_pass         <= 4'd0;
            r_result_ready <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_pass         <= n_pass;
            r_result_ready <= n_result_ready;
        end
    end

endmodule

// ----- rtl/kirs_dp.sv -----
// Datapath: config registers, key and frame memories, address counters.
module kirs_dp import kirs_pkg::*; #(
    parameter int KEY_DEPTH = 16384,
    parameter int MAX_DIM   = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  t_req              i_req,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_res              o_res
);

    localparam int KW = $clog2(KEY_DEPTH);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int FD = MAX_DIM * MAX_DIM;
    localparam int AW = $clog2(FD);
    localparam int CW = AW + 1;

    // memories
    logic [13:0] m_key [KEY_DEPTH];
    logic [23:0] m_a   [FD];
    logic [23:0] m_b   [FD];

    // configuration
    logic [CFG_DW-1:0] r_cfg_rows, r_cfg_cols;
    logic              r_cfg_fwd;

    // frame and pass registers
    logic [CW-1:0] r_wc, r_rc, r_tot, r_cnt;
    logic [DW-1:0] r_R, r_C, r_pr, r_pc;
    logic          r_fwd, r_cw;
    logic [KW-1:0] r_kidx;
    logic          r_key_last;
    logic [13:0]   r_k_q;
    logic [DW-1:0] r_placed, r_x, r_row, r_s, r_col, r_rx;
    logic [DW:0]   r_acc;
    logic [AW-1:0] r_dst_base, r_vbase, r_src, r_dst, r_row_base, r_ystart;

    // memory pipeline
    logic          r_mv_v, r_cp_v, r_rd_v, r_rd_last;
    logic [AW-1:0] r_pend;
    logic [23:0]   r_a_q, r_b_q;
    logic          r_out_valid;
    t_res          r_out;

    logic [DW-1:0] w_rows_c, w_cols_c, w_pr, w_pc;
    logic [CW-1:0] w_total, w_wc_inc;
    logic          w_swap;
    t_pass_kind    w_kind;
    logic          w_a_we, w_b_we, w_k_we;
    logic [AW-1:0] w_a_waddr, w_a_raddr, w_b_waddr, w_ystart_nx;
    logic [23:0]   w_a_wdata, w_b_wdata;
    t_op           w_op;

    function automatic logic [DW-1:0] clamp_dim(input logic [CFG_DW-1:0] v);
        logic [DW-1:0] r;
        if (v == '0)                r = DW'(1);
        else if (32'(v) > MAX_DIM)  r = DW'(MAX_DIM);
        else                        r = DW'(v);
        return r;
    endfunction

    assign w_op        = i_cmd.op;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows <= CFG_DW'(256);
            r_cfg_cols <= CFG_DW'(256);
            r_cfg_fwd  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROWS: r_cfg_rows <= i_cfg_data;
                CFG_COLS: r_cfg_cols <= i_cfg_data;
                CFG_FWD:  r_cfg_fwd  <= i_cfg_data[0];
                default:  ;
            endcase
        end
    end

    // frame size while loading
    assign w_rows_c = clamp_dim(r_cfg_rows);
    assign w_cols_c = clamp_dim(r_cfg_cols);
    assign w_total  = CW'(w_rows_c) * CW'(w_cols_c);
    assign w_wc_inc = r_wc + CW'(r_wc < w_total);

    // pass geometry at pass start
    assign w_swap = pass_swap(i_cmd.pass_idx);
    assign w_kind = pass_kind(i_cmd.pass_idx);
    assign w_pr   = w_swap ? r_C : r_R;
    assign w_pc   = w_swap ? r_R : r_C;
    assign w_ystart_nx = r_cw ? r_ystart + AW'(1) : r_ystart - AW'(1);

    // status to the sequencer
    always_comb begin
        o_stat.full_next   = w_wc_inc >= w_total;
        o_stat.read_last   = (r_rc + CW'(1)) >= r_tot;
        o_stat.cnt_last    = r_cnt == r_tot - CW'(1);
        o_stat.key_last    = r_key_last;
        o_stat.key_hit     = 32'(r_k_q) < 32'(r_pr);
        o_stat.placed_full = r_placed == r_pr;
        o_stat.row_last    = r_x == r_pc - DW'(1);
        o_stat.norm_done   = r_acc < {1'b0, r_pr};
        o_stat.rows_done   = r_row == r_pr;
        o_stat.rot_last    = r_dst == AW'(r_tot - CW'(1));
        o_stat.out_busy    = r_rd_v | r_out_valid;
    end

    // memory port selection
    always_comb begin
        w_k_we    = (w_op == OP_LOAD_KEY) && (32'(i_req.key_index) < KEY_DEPTH);
        w_a_we    = 1'b0;
        w_a_waddr = r_pend;
        w_a_wdata = r_b_q;
        if (w_op == OP_LOAD_PIX && r_wc < w_total) begin
            w_a_we    = 1'b1;
            w_a_waddr = AW'(r_wc);
            w_a_wdata = i_req.pixel_in;
        end else if (r_cp_v) begin
            w_a_we = 1'b1;
        end
        case (w_op)
            OP_READ:     w_a_raddr = AW'(r_rc);
            OP_ROW_MOVE: w_a_raddr = r_src;
            OP_SL_MOVE:  w_a_raddr = r_row_base + AW'(r_col);
            OP_ROT:      w_a_raddr = r_src;
            default:     w_a_raddr = '0;
        endcase
        w_b_we    = r_mv_v;
        w_b_waddr = r_pend;
        w_b_wdata = r_a_q;
        if (w_op == OP_CLEAR) begin
            w_b_we    = 1'b1;
            w_b_waddr = AW'(r_cnt);
            w_b_wdata = '0;
        end
    end

    // key table
    always_ff @(posedge i_clk) begin
        if (w_k_we) m_key[KW'(i_req.key_index)] <= i_req.key_value;
        r_k_q <= m_key[r_kidx];
    end

    // frame store A
    always_ff @(posedge i_clk) begin
        if (w_a_we) m_a[w_a_waddr] <= w_a_wdata;
        r_a_q <= m_a[w_a_raddr];
    end

    // frame store B
    always_ff @(posedge i_clk) begin
        if (w_b_we) m_b[w_b_waddr] <= w_b_wdata;
        r_b_q <= m_b[AW'(r_cnt)];
    end

    // write-behind stage and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv_v      <= 1'b0;
            r_cp_v      <= 1'b0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mv_v <= (w_op == OP_ROW_MOVE) || (w_op == OP_SL_MOVE) || (w_op == OP_ROT);
            r_cp_v <= w_op == OP_COPY;
            r_rd_v <= w_op == OP_READ;
            if (r_rd_v)           r_out_valid <= 1'b1;
            else if (i_res_ready) r_out_valid <= 1'b0;
        end
        case (w_op)
            OP_ROW_MOVE: r_pend <= r_dst;
            OP_SL_MOVE:  r_pend <= r_row_base + AW'(r_x);
            OP_ROT:      r_pend <= r_dst;
            default:     r_pend <= AW'(r_cnt);
        endcase
        if (r_rd_v) r_out <= '{pixel_out: r_a_q, last_pixel: r_rd_last};
    end

    // counters and address generators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc <= '0;
            r_rc <= '0;
            r_tot <= '0;
        end else begin
            case (w_op)
                OP_LOAD_PIX: begin
                    if (r_wc < w_total) r_wc <= r_wc + CW'(1);
                end
                OP_READ: begin
                    r_rd_last <= o_stat.read_last;
                    if (o_stat.read_last) begin
                        r_rc <= '0;
                        r_wc <= '0;
                    end else begin
                        r_rc <= r_rc + CW'(1);
                    end
                end
                OP_START: begin
                    r_R   <= w_rows_c;
                    r_C   <= w_cols_c;
                    r_fwd <= r_cfg_fwd;
                    r_tot <= w_total;
                    r_rc  <= '0;
                end
                OP_PASS_INIT: begin
                    r_pr       <= w_pr;
                    r_pc       <= w_pc;
                    r_cw       <= w_kind == PK_ROT_CW;
                    r_cnt      <= '0;
                    r_kidx     <= '0;
                    r_key_last <= 1'b0;
                    r_placed   <= '0;
                    r_dst_base <= '0;
                    r_row      <= '0;
                    r_row_base <= '0;
                    r_acc      <= '0;
                    r_s        <= '0;
                    r_col      <= '0;
                    r_x        <= '0;
                    r_rx       <= '0;
                    r_dst      <= '0;
                    if (w_kind == PK_ROT_CW) begin
                        r_ystart <= AW'(r_tot) - AW'(w_pc);
                        r_src    <= AW'(r_tot) - AW'(w_pc);
                    end else begin
                        r_ystart <= AW'(w_pc) - AW'(1);
                        r_src    <= AW'(w_pc) - AW'(1);
                    end
                end
                OP_CLEAR, OP_COPY: begin
                    r_cnt <= o_stat.cnt_last ? '0 : r_cnt + CW'(1);
                end
                OP_KEY_RD: begin
                    r_kidx     <= r_kidx + KW'(1);
                    r_key_last <= r_kidx == KW'(KEY_DEPTH - 1);
                end
                OP_KEY_TEST: begin
                    r_vbase <= AW'(r_k_q) * AW'(r_pc);
                end
                OP_ROW_SET: begin
                    r_x <= '0;
                    if (r_fwd) begin
                        r_src <= r_vbase;
                        r_dst <= r_dst_base;
                    end else begin
                        r_src <= r_dst_base;
                        r_dst <= r_vbase;
                    end
                end
                OP_ROW_MOVE: begin
                    r_src <= r_src + AW'(1);
                    r_dst <= r_dst + AW'(1);
                    if (o_stat.row_last) begin
                        r_x        <= '0;
                        r_placed   <= r_placed + DW'(1);
                        r_dst_base <= r_dst_base + AW'(r_pc);
                    end else begin
                        r_x <= r_x + DW'(1);
                    end
                end
                OP_SL_ROW: begin
                    r_x <= '0;
                    if (r_fwd || r_s == '0) r_col <= r_s;
                    else                    r_col <= r_pc - r_s;
                end
                OP_SL_MOVE: begin
                    r_col <= (r_col == r_pc - DW'(1)) ? '0 : r_col + DW'(1);
                    if (o_stat.row_last) begin
                        r_x        <= '0;
                        r_row      <= r_row + DW'(1);
                        r_row_base <= r_row_base + AW'(r_pc);
                        r_acc      <= r_acc + {1'b0, r_pc};
                    end else begin
                        r_x <= r_x + DW'(1);
                    end
                end
                OP_SL_NORM: begin
                    // one step of the running floor(cols*row/rows)
                    if (!o_stat.norm_done) begin
                        r_acc <= r_acc - {1'b0, r_pr};
                        r_s   <= r_s + DW'(1);
                    end
                end
                OP_ROT: begin
                    r_dst <= r_dst + AW'(1);
                    if (r_rx == r_pr - DW'(1)) begin
                        r_rx     <= '0;
                        r_ystart <= w_ystart_nx;
                        r_src    <= w_ystart_nx;
                    end else begin
                        r_rx  <= r_rx + DW'(1);
                        r_src <= r_cw ? r_src - AW'(r_pc) : r_src + AW'(r_pc);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ----- rtl/keyed_image_row_scrambler.sv -----
// Top level of the keyed image row scrambler: sequencer plus datapath.
//
// Channels: request (i_req_valid/o_req_ready, payload i_req), result
// (o_res_valid/i_res_ready, payload o_res), config write (i_cfg_valid/
// o_cfg_ready, i_cfg_index, i_cfg_data; always ready).
// A request with mode 0 writes one key entry, mode 1 writes the next pixel
// in raster order, mode 2 reads the next result pixel. Key and pixel writes
// leave the request side open, but for the last pixel. A read's pixel is
// registered in frame store A and then in the result register, and the
// request side stays closed until that result has been taken. The last
// pixel starts the eleven-pass transform, which holds o_req_ready low.
// Every pass walks the frame through the frame memories, one pixel per
// cycle: a scramble clears R*C pixels, scans the key and moves the kept
// rows, a slant moves R*C pixels with a setup and normalising steps per
// row, a rotation moves R*C, and each pass copies back R*C.
// Reset returns the block to loading with no frame pending; memory contents
// are not cleared. A stalled receiver simply holds the result register.
module keyed_image_row_scrambler import kirs_pkg::*; #(
    parameter int KEY_DEPTH = 16384,
    parameter int MAX_DIM   = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  t_req              i_req,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_res              o_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    kirs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_mode      (i_req.mode),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    kirs_dp #(
        .KEY_DEPTH (KEY_DEPTH),
        .MAX_DIM   (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

endmodule

// ----- rtl/kirs_checker.sv -----
// Port-level checker for the keyed image row scrambler, bound to the top.
`include "assert_macros.svh"
module kirs_checker import kirs_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              o_req_ready,
    input t_req              i_req,
    input logic              o_res_valid,
    input logic              i_res_ready,
    input t_res              o_res,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic [1:0]        i_cfg_index,
    input logic [CFG_DW-1:0] i_cfg_data
);

    // a result holds until taken
    `KIRS_ASSERT_NEXT(a_res_hold, o_res_valid && !i_res_ready, o_res_valid, "result dropped")
    `KIRS_ASSERT_NEXT(a_res_stable, o_res_valid && !i_res_ready, $stable(o_res), "result changed")
    // every new result answers an accepted read request
    `KIRS_ASSERT_NOW(a_res_cause, $rose(o_res_valid), $past(i_req_valid && o_req_ready && (i_req.mode == MODE_READ), 2), "result without read")
    // no request is taken while a result waits
    `KIRS_ASSERT_NOW(a_one_out, o_res_valid, !o_req_ready, "request taken with result pending")

endmodule

bind keyed_image_row_scrambler kirs_checker u_kirs_checker (.*);

// ----- dv/tb_keyed_image_row_scrambler.sv -----
// Self-checking testbench for the keyed image row scrambler.
`timescale 1ns / 1ps

module tb_keyed_image_row_scrambler;
    import kirs_pkg::*;

    localparam int KEY_DEPTH  = 16384;
    localparam int MAX_DIM    = 256;
    localparam int FRAME_MAX  = MAX_DIM * MAX_DIM;
    // key entries written up front: every row number once plus spare slots
    localparam int KEY_PREFIX = 272;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_req_valid;
    logic              o_req_ready;
    t_req              i_req;
    logic              o_res_valid;
    logic              i_res_ready;
    t_res              o_res;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [CFG_DW-1:0] i_cfg_data;

    keyed_image_row_scrambler #(
        .KEY_DEPTH(KEY_DEPTH),
        .MAX_DIM  (MAX_DIM)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_res_valid(o_res_valid),
        .i_res_ready(i_res_ready),
        .o_res      (o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // directed stimulus row
    typedef struct {
        t_req req;
        bit   typed;
        bit   has_res;
        t_res res;
    } dir_row_t;

    // scrambler shadow state
    bit [13:0]       keys [KEY_DEPTH];
    bit [23:0]       img_a [FRAME_MAX];
    bit [23:0]       img_b [FRAME_MAX];
    int unsigned     wr_cnt, rd_cnt, out_rows, out_cols;
    bit              frame_ready;
    bit [CFG_DW-1:0] rows_reg, cols_reg;
    bit              fwd_reg;

    // prefix slots that random key writes may change freely
    int unsigned spare_pos [$];

    t_res pixels_due [$];
    int   n_err;
    bit   quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #200_000_000;
        $display("** keyed_image_row_scrambler: FAILED **");
        $finish;
    end

    function automatic int unsigned clamp_dim(input bit [CFG_DW-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic void copy_back(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) img_a[i] = img_b[i];
    endfunction

    // keyed row gather (forward) or scatter (inverse)
    function automatic void row_scramble(input int unsigned rows, input int unsigned cols,
                                         input bit fwd);
        int unsigned placed;
        int unsigned v;
        placed = 0;
        for (int unsigned i = 0; i < rows * cols; i++) img_b[i] = '0;
        for (int k = 0; k < KEY_DEPTH; k++) begin
            v = keys[k];
            if (v >= rows) continue;
            if (placed >= rows) break;
            for (int unsigned x = 0; x < cols; x++) begin
                if (fwd) img_b[placed * cols + x] = img_a[v * cols + x];
                else     img_b[v * cols + x] = img_a[placed * cols + x];
            end
            placed++;
        end
        copy_back(rows * cols);
    endfunction

    function automatic void row_slant(input int unsigned rows, input int unsigned cols,
                                      input bit fwd);
        int unsigned s, sh;
        for (int unsigned i = 0; i < rows; i++) begin
            s  = (cols * i) / rows;
            sh = fwd ? s : (cols - s) % cols;
            for (int unsigned x = 0; x < cols; x++)
                img_b[i * cols + x] = img_a[i * cols + (x + sh) % cols];
        end
        copy_back(rows * cols);
    endfunction

    function automatic void rotate(input int unsigned rows, input int unsigned cols,
                                   input bit cw);
        int unsigned src;
        for (int unsigned y = 0; y < cols; y++) begin
            for (int unsigned x = 0; x < rows; x++) begin
                src = cw ? (rows - 1 - x) * cols + y : x * cols + (cols - 1 - y);
                img_b[y * rows + x] = img_a[src];
            end
        end
        copy_back(rows * cols);
    endfunction

    function automatic void run_scramble();
        int unsigned r, c;
        bit f;
        r = clamp_dim(rows_reg);
        c = clamp_dim(cols_reg);
        f = fwd_reg;
        row_scramble(r, c, f); row_slant(r, c, f); row_scramble(r, c, f);
        rotate(r, c, 1'b1);
        row_scramble(c, r, f); row_slant(c, r, f); row_scramble(c, r, f);
        rotate(c, r, 1'b0);
        row_scramble(r, c, f); row_slant(r, c, f); row_scramble(r, c, f);
        out_rows    = r;
        out_cols    = c;
        frame_ready = 1'b1;
        rd_cnt      = 0;
    endfunction

    // expected outcome of one accepted request
    function automatic void predict_pixel(input t_req r, output bit got, output t_res res);
        int unsigned total;
        got = 1'b0;
        res = '0;
        case (r.mode)
            MODE_KEY: begin
                keys[r.key_index] = r.key_index < KEY_DEPTH ? r.key_value : keys[r.key_index];
            end
            MODE_PIX: begin
                if (!frame_ready) begin
                    total = clamp_dim(rows_reg) * clamp_dim(cols_reg);
                    if (wr_cnt < total) begin
                        img_a[wr_cnt] = r.pixel_in;
                        wr_cnt++;
                    end
                    if (wr_cnt >= total) run_scramble();
                end
            end
            MODE_READ: begin
                if (frame_ready) begin
                    total          = out_rows * out_cols;
                    got            = 1'b1;
                    res.pixel_out  = img_a[rd_cnt % total];
                    res.last_pixel = (rd_cnt + 1 >= total);
                    rd_cnt++;
                    if (res.last_pixel) begin
                        frame_ready = 1'b0;
                        rd_cnt      = 0;
                        wr_cnt      = 0;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic bit take_gap();
        return !quiet && ($urandom_range(99) < 36);
    endfunction

    // send one request; valid only drops during an idle gap
    task automatic send_req(input t_req r, input bit typed = 1'b0,
                            input bit t_has = 1'b0, input t_res t_val = '0);
        bit   got;
        t_res res;
        while (take_gap()) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        predict_pixel(r, got, res);
        if (typed) begin
            got = t_has;
            res = t_val;
        end
        if (got) pixels_due = {pixels_due, res};
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DW-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ROWS: rows_reg = val[CFG_DW-1:0];
            CFG_COLS: cols_reg = val[CFG_DW-1:0];
            CFG_FWD:  fwd_reg  = val[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain results, then let any background work finish
    task automatic wait_drained();
        i_req_valid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic bit [13:0] rand_key_val();
        case ($urandom_range(2))
            0:       return $urandom_range(20);
            1:       return $urandom_range(300);
            default: return $urandom_range(16383);
        endcase
    endfunction

    // random key writes stay off the row-number slots of the prefix
    function automatic bit [13:0] rand_key_idx();
        if (spare_pos.size() != 0 && $urandom_range(1) == 0)
            return 14'(spare_pos[$urandom_range(spare_pos.size() - 1)]);
        return 14'($urandom_range(KEY_DEPTH - 1, KEY_PREFIX));
    endfunction

    function automatic t_req rand_req();
        t_req r;
        r.mode      = MODE_PIX;
        r.key_index = rand_key_idx();
        r.key_value = rand_key_val();
        r.pixel_in  = $urandom;
        return r;
    endfunction

    // load pixels until the transform starts, then read the frame out
    task automatic run_frame(input bit hold_mid);
        t_req r;
        int unsigned p;
        while (!frame_ready) begin
            r = rand_req();
            p = $urandom_range(99);
            if (p >= 95)      r.mode = 2'd3;
            else if (p >= 90) r.mode = MODE_READ;
            else if (p >= 86) r.mode = MODE_KEY;
            send_req(r);
        end
        while (frame_ready) begin
            r = rand_req();
            p = $urandom_range(99);
            r.mode = MODE_READ;
            if (p >= 98)      r.mode = 2'd3;
            else if (p >= 96) r.mode = MODE_KEY;
            else if (p >= 92) r.mode = MODE_PIX;
            if (hold_mid && rd_cnt == 100) begin
                i_req_valid <= 1'b0;
                while (pixels_due.size() != 0) @(posedge i_clk);
            end
            send_req(r);
        end
    endtask

    // result receiver and checker
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (pixels_due.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected pixel %h last %b", o_res.pixel_out, o_res.last_pixel);
            end else begin
                want = pixels_due.pop_front();
                if (o_res.pixel_out !== want.pixel_out || o_res.last_pixel !== want.last_pixel)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("pixel mismatch: exp %h/%b got %h/%b", want.pixel_out,
                                 want.last_pixel, o_res.pixel_out, o_res.last_pixel);
                end
            end
        end
        i_res_ready <= !take_gap();
    end

    initial begin
        dir_row_t    dir_tab [$];
        dir_row_t    row;
        t_req        r;
        int unsigned perm [MAX_DIM];
        int unsigned tmp, j, n_perm, n_spare, next_perm;
        n_err       = 0;
        quiet       = 1'b0;
        wr_cnt      = 0;
        rd_cnt      = 0;
        out_rows    = 0;
        out_cols    = 0;
        frame_ready = 1'b0;
        rows_reg    = 9'd256;
        cols_reg    = 9'd256;
        fwd_reg     = 1'b1;
        for (int k = 0; k < KEY_DEPTH; k++) keys[k] = '0;
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_ROWS;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first frame: size out of range both ways clamps to 1 x 256
        write_reg(CFG_ROWS, 0);
        write_reg(CFG_COLS, 511);
        write_reg(CFG_FWD, 1);

        // directed requests: none of these can return a pixel
        row = '{req: '0, typed: 1'b1, has_res: 1'b0, res: '0};
        row.req.mode = MODE_READ;                                   dir_tab = {dir_tab, row};
        row.req = '1; row.req.mode = 2'd3;                          dir_tab = {dir_tab, row};
        row.req = '0; row.req.mode = MODE_KEY;
        row.req.key_value = 14'h3FFF;                               dir_tab = {dir_tab, row};
        row.req.key_index = 14'h3FFF; row.req.key_value = '0;       dir_tab = {dir_tab, row};
        row.req.key_index = 14'h2AAA; row.req.key_value = 14'h1555; dir_tab = {dir_tab, row};
        row.req.key_index = 14'h1555; row.req.key_value = 14'h0001; dir_tab = {dir_tab, row};
        row.req = '0; row.req.mode = MODE_PIX;                      dir_tab = {dir_tab, row};
        row.req.pixel_in = 24'hFFFFFF;                              dir_tab = {dir_tab, row};
        row.req.pixel_in = 24'hA5A5A5;                              dir_tab = {dir_tab, row};
        row.req = '1; row.req.mode = MODE_READ;                     dir_tab = {dir_tab, row};
        foreach (dir_tab[i])
            send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].has_res, dir_tab[i].res);

        // key prefix: each row number once, shuffled, mixed with spare slots,
        // so every scramble places all its rows before leaving the prefix
        for (int i = 0; i < MAX_DIM; i++) perm[i] = i;
        for (int i = MAX_DIM - 1; i > 0; i--) begin
            j       = $urandom_range(i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        n_perm    = MAX_DIM;
        n_spare   = KEY_PREFIX - MAX_DIM;
        next_perm = 0;
        for (int k = 0; k < KEY_PREFIX; k++) begin
            r           = rand_req();
            r.mode      = MODE_KEY;
            r.key_index = 14'(k);
            if ($urandom_range(n_perm + n_spare - 1) < n_spare) begin
                n_spare--;
                spare_pos = {spare_pos, k};
            end else begin
                r.key_value = 14'(perm[next_perm]);
                next_perm++;
                n_perm--;
            end
            send_req(r);
        end
        run_frame(1'b1);
        wait_drained();

        // tall single-column frame, inverse, with no idling on either side
        quiet = 1'b1;
        write_reg(CFG_ROWS, 64);
        write_reg(CFG_COLS, 1);
        write_reg(CFG_FWD, 0);
        run_frame(1'b0);
        wait_drained();
        quiet = 1'b0;

        // size shrinks below the pixels already written: transform starts early
        write_reg(CFG_ROWS, 5);
        write_reg(CFG_COLS, 6);
        write_reg(CFG_FWD, $urandom_range(1));
        for (int i = 0; i < 20; i++) send_req(rand_req());
        wait_drained();
        write_reg(CFG_ROWS, 3);
        write_reg(CFG_COLS, 4);
        run_frame(1'b0);
        wait_drained();

        // random small frame
        write_reg(CFG_ROWS, $urandom_range(2, 16));
        write_reg(CFG_COLS, $urandom_range(2, 16));
        write_reg(CFG_FWD, $urandom_range(1));
        run_frame(1'b0);
        wait_drained();

        if (n_err == 0) begin
            $display("** keyed_image_row_scrambler: PASSED **");
        end else begin
            $display("** keyed_image_row_scrambler: FAILED **");
        end
        $finish;
    end

endmodule
